// File: src/gak_pkg.sv
// Shared types, constants and channel tables for the gamepad autorepeat key encoder.
// No dependencies; imported by every module of the block except gak_checker.
`default_nettype none
package gak_pkg;

  localparam int CHANNELS  = 20;
  localparam int TIME_BITS = 32;
  localparam int AXES      = 8;

  // Register indexes of the configuration port
  localparam logic [2:0] CFG_IDX_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_IDX_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_IDX_INITIAL   = 3'd2;
  localparam logic [2:0] CFG_IDX_MIN       = 3'd3;
  localparam logic [2:0] CFG_IDX_MAX       = 3'd4;
  localparam logic [2:0] CFG_IDX_STEP      = 3'd5;

  // Register reset values
  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [14:0] RST_THRESHOLD = 15'd10000;
  localparam logic [9:0]  RST_INITIAL   = 10'd150;
  localparam logic [9:0]  RST_MIN       = 10'd30;
  localparam logic [9:0]  RST_MAX       = 10'd400;
  localparam logic [7:0]  RST_STEP      = 8'd10;

  // Period adjust channels
  localparam int CH_SHORTER = 18;
  localparam int CH_LONGER  = 19;

  typedef logic [7:0] code_t;
  typedef logic [AXES-1:0][15:0] axes_t;

  // Key code per channel
  localparam code_t CHAN_CODE [CHANNELS] = '{
    8'd75, 8'd77, 8'd80, 8'd72, 8'd32, 8'd90, 8'd67, 8'd82, 8'd72, 8'd82,
    8'd72, 8'd72, 8'd82, 8'd13, 8'd67, 8'd72, 8'd27, 8'd13, 8'd45, 8'd43
  };

  // Bit i set: channel i overwrites the code; clear: writes only if none set
  localparam logic [CHANNELS-1:0] CHAN_OVERWRITE = 20'b1111_0000_0110_0111_1111;

  typedef struct packed {
    logic        enable;
    logic [14:0] threshold;
    logic [9:0]  repeat_min;
    logic [9:0]  repeat_max;
    logic [7:0]  repeat_step;
  } cfg_t;

  typedef struct packed {
    code_t      key_code;
    logic [9:0] period_now;
  } result_t;

endpackage
`default_nettype wire

// File: src/gak_activity_decode.sv
// Channel activity decode: thresholds the axes and maps buttons to channels.
// Depends on gak_pkg.
`default_nettype none
module gak_activity_decode (
  input  wire gak_pkg::axes_t               axes,
  input  wire logic [9:0]                   button_bits,
  input  wire logic [14:0]                  threshold,
  output logic [gak_pkg::CHANNELS-1:0]      act
);
  import gak_pkg::*;

  logic [AXES-1:0] pos;
  logic [AXES-1:0] neg;

  // Per-axis compare against +T and -T in 17-bit signed arithmetic
  always_comb begin
    logic signed [16:0] thr_s;
    logic signed [16:0] v_s;
    thr_s = $signed({2'b00, threshold});
    for (int k = 0; k < AXES; k++) begin
      v_s    = $signed({axes[k][15], axes[k]});
      pos[k] = v_s > thr_s;
      neg[k] = v_s < -thr_s;
    end
  end

  // Channel map
  always_comb begin
    act        = '0;
    act[0]     = neg[6] | neg[0];
    act[1]     = pos[6] | pos[0];
    act[2]     = pos[7] | pos[1];
    act[6:3]   = button_bits[3:0];
    act[8:7]   = button_bits[5:4];
    act[9]     = pos[4];
    act[10]    = pos[5];
    act[11]    = pos[2];
    act[12]    = neg[2];
    act[13]    = pos[3];
    act[14]    = neg[3];
    act[15]    = neg[7];
    act[19:16] = button_bits[9:6];
  end

endmodule
`default_nettype wire

// File: src/gak_fire_engine.sv
// Fire evaluation, key code selection and per-channel repeat state.
// Depends on gak_pkg; fed by gak_activity_decode through the top level.
`default_nettype none
module gak_fire_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic [gak_pkg::CHANNELS-1:0]  act,
  input  wire logic [31:0]                   time_ms,
  input  wire gak_pkg::cfg_t                 cfg,
  output gak_pkg::result_t                   res
);
  import gak_pkg::*;

  logic [CHANNELS-1:0]  was_active_r;
  logic [CHANNELS-1:0]  armed_r;
  logic [TIME_BITS-1:0] lft_r [CHANNELS];
  logic [9:0]           period_r;

  logic [TIME_BITS-1:0] now;
  logic [CHANNELS-1:0]  fire;
  logic [9:0]           period_a;
  logic [9:0]           period_nxt;
  code_t                code;

  assign now = TIME_BITS'(time_ms);

  // Shorten step: saturate at zero, then clamp up to repeat_min.
  // The shorten channel's own fire test is repeated here against the held period.
  always_comb begin
    logic [10:0]          diff;
    logic [TIME_BITS-1:0] el_short;
    logic                 fire_short;
    el_short   = now - lft_r[CH_SHORTER];
    fire_short = cfg.enable && act[CH_SHORTER] &&
                 (!was_active_r[CH_SHORTER] ||
                  (armed_r[CH_SHORTER] && (el_short >= TIME_BITS'(period_r))));
    diff = {1'b0, period_r} - {3'b000, cfg.repeat_step};
    if (diff[10]) begin
      period_a = '0;
    end else begin
      period_a = diff[9:0];
    end
    if (period_a < cfg.repeat_min) begin
      period_a = cfg.repeat_min;
    end
    if (!fire_short) begin
      period_a = period_r;
    end
  end

  // Per-channel fire test; the lengthen channel sees the shortened period
  always_comb begin
    logic [TIME_BITS-1:0] elapsed;
    logic [9:0]           per;
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed = now - lft_r[i];
      per     = (i == CH_LONGER) ? period_a : period_r;
      fire[i] = cfg.enable && act[i] &&
                (!was_active_r[i] ||
                 (armed_r[i] && (elapsed >= TIME_BITS'(per))));
    end
  end

  // Lengthen step: clamp down to repeat_max
  always_comb begin
    logic [10:0] sum;
    sum = {1'b0, period_a} + {3'b000, cfg.repeat_step};
    if (sum > {1'b0, cfg.repeat_max}) begin
      period_nxt = cfg.repeat_max;
    end else begin
      period_nxt = sum[9:0];
    end
    if (!fire[CH_LONGER]) begin
      period_nxt = period_a;
    end
  end

  // Code select: last firing overwrite channel, else first firing channel
  always_comb begin
    logic [CHANNELS-1:0] ow_fire;
    logic                any_ow;
    logic                sel;
    ow_fire = fire & CHAN_OVERWRITE;
    any_ow  = |ow_fire;
    code    = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (any_ow) begin
        sel = ow_fire[i] && !(|(ow_fire & ({CHANNELS{1'b1}} << (i + 1))));
      end else begin
        sel = fire[i] && !(|(fire & ~({CHANNELS{1'b1}} << i)));
      end
      code = code | (sel ? CHAN_CODE[i] : 8'd0);
    end
  end

  assign res.key_code   = code;
  assign res.period_now = period_nxt;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_active_r <= '0;
      armed_r      <= '0;
      period_r     <= RST_INITIAL;
    end else if (advance && cfg.enable) begin
      was_active_r <= act;
      armed_r      <= armed_r | fire;
      period_r     <= period_nxt;
    end
  end

  // Last fire times; only read once the channel is armed
  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (advance && fire[i]) begin
        lft_r[i] <= now;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/gamepad_autorepeat_key_encoder_core.sv
// Pipeline: input register, combinational compute, result register.
// One request per cycle unless a stalled full result holds the pipe; the per-channel
// repeat state is read and updated in the compute logic between the two registers.
// Reset (rst_n low, synchronous): both stages empty, registers to defaults,
// activity and armed bits cleared, repeat period loaded with 150 ms.
`default_nettype none
module gamepad_autorepeat_key_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_axis_left_x,
  input  wire logic [15:0] in_axis_left_y,
  input  wire logic [15:0] in_axis_right_x,
  input  wire logic [15:0] in_axis_right_y,
  input  wire logic [15:0] in_axis_left_trigger,
  input  wire logic [15:0] in_axis_right_trigger,
  input  wire logic [15:0] in_axis_pad_x,
  input  wire logic [15:0] in_axis_pad_y,
  input  wire logic [9:0]  in_button_bits,
  input  wire logic [31:0] in_time_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_key_code,
  output logic [9:0]       out_period_now,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import gak_pkg::*;

  cfg_t        cfg_r;
  logic        s1_valid_r;
  axes_t       s1_axes_r;
  logic [9:0]  s1_buttons_r;
  logic [31:0] s1_time_r;
  logic        out_valid_r;
  result_t     out_res_r;

  logic                out_can;
  logic                s1_can;
  logic                advance;
  logic [CHANNELS-1:0] act;
  result_t             res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= RST_ENABLE;
      cfg_r.threshold   <= RST_THRESHOLD;
      cfg_r.repeat_min  <= RST_MIN;
      cfg_r.repeat_max  <= RST_MAX;
      cfg_r.repeat_step <= RST_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_ENABLE:    cfg_r.enable      <= cfg_data[0];
        CFG_IDX_THRESHOLD: cfg_r.threshold   <= cfg_data;
        CFG_IDX_INITIAL: begin
          // the written value is ignored; reset loads the default initial period
        end
        CFG_IDX_MIN:       cfg_r.repeat_min  <= cfg_data[9:0];
        CFG_IDX_MAX:       cfg_r.repeat_max  <= cfg_data[9:0];
        CFG_IDX_STEP:      cfg_r.repeat_step <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control
  assign out_can  = !out_valid_r || !out_stall;
  assign s1_can   = !s1_valid_r || out_can;
  assign advance  = s1_valid_r && out_can;
  assign in_stall = !s1_can;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_can) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_can) begin
      s1_axes_r    <= {in_axis_pad_y, in_axis_pad_x, in_axis_right_trigger,
                       in_axis_left_trigger, in_axis_right_y, in_axis_right_x,
                       in_axis_left_y, in_axis_left_x};
      s1_buttons_r <= in_button_bits;
      s1_time_r    <= in_time_ms;
    end
  end

  gak_activity_decode u_decode (
    .axes        (s1_axes_r),
    .button_bits (s1_buttons_r),
    .threshold   (cfg_r.threshold),
    .act         (act)
  );

  gak_fire_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .act     (act),
    .time_ms (s1_time_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_can) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = out_res_r.key_code;
  assign out_period_now = out_res_r.period_now;

endmodule
`default_nettype wire

// File: src/gak_checker.sv
// Port-level checks for the gamepad autorepeat key encoder, bound to the top level.
// No package dependency; attaches to gamepad_autorepeat_key_encoder_core.
`default_nettype none
module gak_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_key_code,
  input wire logic [9:0]  out_period_now
);

  logic       have_r;
  logic [9:0] last_period_r;

  // Period of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      have_r        <= 1'b1;
      last_period_r <= out_period_now;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_code) &&
    $stable(out_period_now))
    else $error("stalled result changed");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input only stalls when the result stage is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Result code is one of the channel codes or zero
  a_code_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_code == 8'd0 || out_key_code == 8'd75 ||
    out_key_code == 8'd77 || out_key_code == 8'd80 || out_key_code == 8'd72 ||
    out_key_code == 8'd32 || out_key_code == 8'd90 || out_key_code == 8'd67 ||
    out_key_code == 8'd82 || out_key_code == 8'd13 || out_key_code == 8'd27 ||
    out_key_code == 8'd45 || out_key_code == 8'd43)
    else $error("unknown key code");

  // A sample with no fire leaves the repeat period unchanged
  a_period_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && have_r && out_key_code == 8'd0 |->
    out_period_now == last_period_r)
    else $error("period moved without a fire");

endmodule

bind gamepad_autorepeat_key_encoder_core gak_checker u_gak_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_key_code   (out_key_code),
  .out_period_now (out_period_now)
);
`default_nettype wire
